// ===== sv/b64le_pkg.sv =====
`timescale 1ns / 1ps

package b64le_pkg;

    localparam int LINE_CHARS_DEF  = 76;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int MAX_CHARS       = 6;

    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    // One encoded run: the characters caused by one input byte.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [2:0]                last_idx;
        logic                      fin;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic busy;
        logic last;
    } t_bstat;

    // Standard base64 alphabet.
    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] r;
        w = {2'b00, v};
        if (v < 6'd26) begin
            r = 8'h41 + w;
        end else if (v < 6'd52) begin
            r = 8'h61 + w - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + w - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

// ===== sv/b64le_front.sv =====
`timescale 1ns / 1ps

module b64le_front #(
    parameter int LINE_CHARS = b64le_pkg::LINE_CHARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_final_byte,
    input  b64le_pkg::t_qstat i_qstat,
    output logic              o_push,
    output b64le_pkg::t_job   o_job
);
    import b64le_pkg::*;

    localparam int GPL_RAW = LINE_CHARS / 4;
    localparam int GPL     = (GPL_RAW == 0) ? 1 : GPL_RAW;
    localparam logic [5:0] GPL_W = 6'(GPL);

    logic [7:0] r_pend0, r_pend1;
    logic [1:0] r_phase, n_phase;
    logic [4:0] r_groups, n_groups;

    logic       accept;
    logic [5:0] g_next;
    logic       wrap;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;
    assign g_next  = {1'b0, r_groups} + 6'd1;
    assign wrap    = (g_next >= GPL_W);

    always_comb begin
        o_job          = '0;
        o_push         = 1'b0;
        n_phase        = r_phase;
        n_groups       = r_groups;
        o_job.fin      = i_final_byte;
        o_job.last_idx = 3'd3;
        case (r_phase)
            2'd1: begin
                o_job.chars[0] = b64_sym(r_pend0[7:2]);
                o_job.chars[1] = b64_sym({r_pend0[1:0], i_data_byte[7:4]});
                o_job.chars[2] = b64_sym({i_data_byte[3:0], 2'b00});
                o_job.chars[3] = CHAR_PAD;
                o_push         = accept && i_final_byte;
                n_phase        = 2'd2;
            end
            2'd2: begin
                o_job.chars[0] = b64_sym(r_pend0[7:2]);
                o_job.chars[1] = b64_sym({r_pend0[1:0], r_pend1[7:4]});
                o_job.chars[2] = b64_sym({r_pend1[3:0], i_data_byte[7:6]});
                o_job.chars[3] = b64_sym(i_data_byte[5:0]);
                o_job.chars[4] = CHAR_CR;
                o_job.chars[5] = CHAR_LF;
                o_job.last_idx = wrap ? 3'd5 : 3'd3;
                o_push         = accept;
                n_phase        = 2'd0;
                n_groups       = wrap ? 5'd0 : g_next[4:0];
            end
            default: begin
                // phase 0 (and the unused code 3)
                o_job.chars[0] = b64_sym(i_data_byte[7:2]);
                o_job.chars[1] = b64_sym({i_data_byte[1:0], 4'b0000});
                o_job.chars[2] = CHAR_PAD;
                o_job.chars[3] = CHAR_PAD;
                o_push         = accept && i_final_byte;
                n_phase        = 2'd1;
            end
        endcase
        if (i_final_byte) begin
            n_phase  = 2'd0;
            n_groups = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 2'd0;
            r_groups <= 5'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_groups <= n_groups;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_phase == 2'd1) begin
                r_pend1 <= i_data_byte;
            end else if (r_phase != 2'd2) begin
                r_pend0 <= i_data_byte;
            end
        end
    end

endmodule

// ===== sv/b64le_queue.sv =====
`timescale 1ns / 1ps

module b64le_queue #(
    parameter int DEPTH = b64le_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64le_pkg::t_job   i_job,
    input  logic              i_pop,
    output b64le_pkg::t_job   o_job,
    output b64le_pkg::t_qstat o_stat
);
    import b64le_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ===== sv/b64le_back.sv =====
`timescale 1ns / 1ps

module b64le_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64le_pkg::t_job   i_job,
    input  b64le_pkg::t_qstat i_qstat,
    output logic              o_pop,
    output b64le_pkg::t_bstat o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_char,
    output logic              o_run_end,
    output logic              o_message_end
);
    import b64le_pkg::*;

    t_job       r_job;
    logic [2:0] r_idx;
    logic       r_busy;
    logic       r_ovalid;
    logic [7:0] r_char;
    logic       r_run_end, r_msg_end;

    logic can_load, take, last;

    assign can_load = !r_ovalid || i_ready;
    assign take     = r_busy && can_load;
    assign last     = (r_idx == r_job.last_idx);
    // next run is fetched as the current one hands over its last character
    assign o_pop    = !i_qstat.empty && (!r_busy || (take && last));

    assign o_stat.busy = r_busy;
    assign o_stat.last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (take && last) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_idx <= 3'd0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
        if (take) begin
            r_char    <= r_job.chars[r_idx];
            r_run_end <= last;
            r_msg_end <= last && r_job.fin;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_char    = r_char;
    assign o_run_end     = r_run_end;
    assign o_message_end = r_msg_end;

endmodule

// ===== sv/base64_line_encoder_core.sv =====
`timescale 1ns / 1ps
// base64 encoder with MIME line wrapping.
// Input channel (i_valid/o_ready): one message byte per request, with
// i_final_byte set on the last byte. Output channel (o_valid/i_ready): one
// character per request - base64 symbol, '=', CR or LF. o_run_end marks the
// last character caused by an input byte, o_message_end the last character
// of the message. CR LF follows every LINE_CHARS/4 groups.
// Once the byte that completes a run is accepted, the run passes through the
// run queue and the back end's run register to the output register. A byte
// that leaves its group open gives no output and is taken while the queue has room.
// Throughput: one character per cycle while the receiver is ready, set by the
// single output register. A byte is accepted every cycle while the run queue
// (QUEUE_DEPTH runs of up to six characters) has room; over a long message
// the character output then sets the byte rate.
// Reset clears the group position, the line count and all valid flags.
// When the receiver stalls, the output register holds its character, the
// queue fills, and o_ready falls once the queue is full.
module base64_line_encoder_core #(
    parameter int LINE_CHARS  = b64le_pkg::LINE_CHARS_DEF,
    parameter int QUEUE_DEPTH = b64le_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_run_end,
    output logic       o_message_end
);
    import b64le_pkg::*;

    t_job   w_push_job, w_pop_job;
    t_qstat w_qstat;
    t_bstat w_bstat;
    logic   w_push, w_pop;

    // front: group assembly, line counting, run building
    b64le_front #(
        .LINE_CHARS(LINE_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_final_byte(i_final_byte),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // run queue decouples byte intake from character output
    b64le_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_push_job),
        .i_pop  (w_pop),
        .o_job  (w_pop_job),
        .o_stat (w_qstat)
    );

    // back: serializes each run, one character per cycle while the receiver is ready
    b64le_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_pop_job),
        .i_qstat      (w_qstat),
        .o_pop        (w_pop),
        .o_stat       (w_bstat),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_run_end    (o_run_end),
        .o_message_end(o_message_end)
    );

`ifndef SYNTHESIS
    // message end always closes a run
    a_msg_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_message_end || o_run_end))
        else $error("message_end without run_end");

    // a final byte always leaves a run queued or in the back end
    a_final_run_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_final_byte) |=> (w_bstat.busy || !w_qstat.empty))
        else $error("final byte produced no run");

    // the back end never fetches a run while still mid-run
    a_pop_at_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!w_bstat.busy || w_bstat.last))
        else $error("run fetched before current run ended");
`endif

endmodule
